/* rtl/convex_polygon_validator_unit_macros.svh */
// Assertion macros shared by the convex polygon validator checkers.
`ifndef CONVEX_POLYGON_VALIDATOR_UNIT_MACROS_SVH
`define CONVEX_POLYGON_VALIDATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define CPV_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define CPV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/cpv_pkg.sv */
// Shared constants, codes and types of the convex polygon validator.
`default_nettype none

package cpv_pkg;

   localparam int MAX_VERTICES_DEF = 1024;
   localparam int COORD_BITS_DEF   = 16;

   localparam int AREA_BITS     = 43;
   localparam int TURN_TOL_BITS = 32;
   localparam int AREA_TOL_BITS = 42;
   localparam int CSR_DATA_BITS = 42;
   localparam int CSR_INDEX_BITS = 1;

   localparam int STATUS_BITS = 3;
   localparam int TURN_BITS   = 2;

   // Corner lanes: the corner ending at the new vertex, then the two wrap-around corners.
   localparam int CORNER_LANES = 3;
   // Edge lanes: the edge into the new vertex, then the closing edge.
   localparam int EDGE_LANES   = 2;
   // Point slots: older recent, newer recent, new vertex, first, second.
   localparam int POINT_SLOTS  = 5;

   localparam logic [STATUS_BITS-1:0] STATUS_OK         = 3'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_TOO_FEW    = 3'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_ZERO_AREA  = 3'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_COLLINEAR  = 3'd3;
   localparam logic [STATUS_BITS-1:0] STATUS_NOT_CONVEX = 3'd4;
   localparam logic [STATUS_BITS-1:0] STATUS_CLOCKWISE  = 3'd5;
   localparam logic [STATUS_BITS-1:0] STATUS_TOO_MANY   = 3'd6;

   // A flat corner and "no sign agreed yet" share the zero code.
   localparam logic [TURN_BITS-1:0] TURN_NONE  = 2'd0;
   localparam logic [TURN_BITS-1:0] TURN_LEFT  = 2'd1;
   localparam logic [TURN_BITS-1:0] TURN_RIGHT = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TURN_TOL = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AREA_TOL = 1'd1;

   typedef struct packed {
      logic                    valid;
      logic                    last;
      logic                    too_many;
      logic                    few;
      logic [CORNER_LANES-1:0] corner_en;
      logic [EDGE_LANES-1:0]   edge_en;
   } cpv_ctl_type;

endpackage

`default_nettype wire

/* rtl/convex_polygon_validator_unit.sv */
// Top level of the streaming convex polygon validator with its configuration registers.
`default_nettype none

// Streams polygon vertices, one signed Q8.8 (x, y) pair per request, with req_last_vertex
// set on the final vertex, and returns one response per polygon: a status code (ok, too
// few, zero area, collinear corner, not convex, clockwise, too many) and twice the signed
// shoelace area in Q16.16. A new vertex is accepted in every cycle in which req_stall is low.
// The pipeline runs in six register stages: input register with vertex history, products,
// differences, turn classification, sign agreement with area accumulation, and the response
// register. The only stall comes from the response side: when the response register
// holds an untaken result and rsp_stall is high, the whole pipeline freezes and req_stall
// is raised. Corners are checked in vertex order; the two wrap-around corners and the
// closing edge are evaluated together with the last vertex. Above MAX_VERTICES vertices
// the rest of the polygon is dropped and the response reports too many with a zero area.
// The two tolerances (turn at index 0, area at index 1) are written through the csr port,
// which is always ready, and are meant to be changed only while no polygon is in flight.
module convex_polygon_validator_unit #(
   parameter int MAX_VERTICES = cpv_pkg::MAX_VERTICES_DEF,
   parameter int COORD_BITS   = cpv_pkg::COORD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Vertex requests.
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [COORD_BITS-1:0]          req_vertex_x,
   input  logic signed [COORD_BITS-1:0]          req_vertex_y,
   input  logic                                  req_last_vertex,
   // Polygon results.
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [cpv_pkg::STATUS_BITS-1:0]       rsp_status,
   output logic signed [cpv_pkg::AREA_BITS-1:0]  rsp_double_area,
   // Configuration writes.
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [cpv_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [cpv_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import cpv_pkg::*;

   // The pipeline moves as a whole unless a finished result is being held back.
   logic advance;

   // Tolerances are kept together with their negations so that the compare stages
   // see both band edges without an extra adder.
   logic [TURN_TOL_BITS-1:0]        turn_tol_ff, turn_tol_in;
   logic signed [TURN_TOL_BITS:0]   turn_tol_neg_ff, turn_tol_neg_in;
   logic [AREA_TOL_BITS-1:0]        area_tol_ff, area_tol_in;
   logic signed [AREA_BITS-1:0]     area_tol_neg_ff, area_tol_neg_in;

   logic signed [COORD_BITS-1:0]    pt_x [POINT_SLOTS];
   logic signed [COORD_BITS-1:0]    pt_y [POINT_SLOTS];
   cpv_ctl_type                     ctl_s1, ctl_s4;
   logic [TURN_BITS-1:0]            turn [CORNER_LANES];
   logic signed [2*COORD_BITS+1:0]  edge_sum;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   // Register write decode.
   always_comb begin
      turn_tol_in     = turn_tol_ff;
      turn_tol_neg_in = turn_tol_neg_ff;
      area_tol_in     = area_tol_ff;
      area_tol_neg_in = area_tol_neg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TURN_TOL: begin
               turn_tol_in     = csr_wdata[TURN_TOL_BITS-1:0];
               turn_tol_neg_in = (TURN_TOL_BITS + 1)'(0)
                               - {1'b0, csr_wdata[TURN_TOL_BITS-1:0]};
            end
            CSR_AREA_TOL: begin
               area_tol_in     = csr_wdata[AREA_TOL_BITS-1:0];
               area_tol_neg_in = AREA_BITS'(0)
                               - AREA_BITS'({1'b0, csr_wdata[AREA_TOL_BITS-1:0]});
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         turn_tol_ff     <= '0;
         turn_tol_neg_ff <= '0;
         area_tol_ff     <= '0;
         area_tol_neg_ff <= '0;
      end else begin
         turn_tol_ff     <= turn_tol_in;
         turn_tol_neg_ff <= turn_tol_neg_in;
         area_tol_ff     <= area_tol_in;
         area_tol_neg_ff <= area_tol_neg_in;
      end
   end

   // Vertex history and the input register.
   cpv_front #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_BITS   (COORD_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .req_valid       (req_valid),
      .req_vertex_x    (req_vertex_x),
      .req_vertex_y    (req_vertex_y),
      .req_last_vertex (req_last_vertex),
      .pt_x            (pt_x),
      .pt_y            (pt_y),
      .ctl             (ctl_s1)
   );

   // Cross products, edge terms and turn classification.
   cpv_arith #(
      .COORD_BITS (COORD_BITS)
   ) u_arith (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .turn_tol     (turn_tol_ff),
      .turn_tol_neg (turn_tol_neg_ff),
      .pt_x         (pt_x),
      .pt_y         (pt_y),
      .ctl_in_s1    (ctl_s1),
      .turn         (turn),
      .edge_sum     (edge_sum),
      .ctl          (ctl_s4)
   );

   // Polygon state and the result register.
   cpv_track #(
      .COORD_BITS (COORD_BITS)
   ) u_track (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .area_tol        (area_tol_ff),
      .area_tol_neg    (area_tol_neg_ff),
      .turn            (turn),
      .edge_sum        (edge_sum),
      .ctl             (ctl_s4),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_double_area (rsp_double_area)
   );

endmodule

`default_nettype wire

/* rtl/cpv_front.sv */
// Vertex history, vertex counting and the input register of the validator pipeline.
`default_nettype none

module cpv_front #(
   parameter int MAX_VERTICES = cpv_pkg::MAX_VERTICES_DEF,
   parameter int COORD_BITS   = cpv_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         req_valid,
   input  logic signed [COORD_BITS-1:0] req_vertex_x,
   input  logic signed [COORD_BITS-1:0] req_vertex_y,
   input  logic                         req_last_vertex,
   output logic signed [COORD_BITS-1:0] pt_x [cpv_pkg::POINT_SLOTS],
   output logic signed [COORD_BITS-1:0] pt_y [cpv_pkg::POINT_SLOTS],
   output cpv_pkg::cpv_ctl_type         ctl
);
   import cpv_pkg::*;

   localparam int CNT_W = $clog2(MAX_VERTICES + 2);
   localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_VERTICES);
   localparam logic [CNT_W-1:0] CNT_OVER = CNT_W'(MAX_VERTICES + 1);

   logic                         accept;
   logic                         active;
   logic [CNT_W-1:0]             count_ff, count_in, count_next;
   logic signed [COORD_BITS-1:0] first_x_ff  [2];
   logic signed [COORD_BITS-1:0] first_y_ff  [2];
   logic signed [COORD_BITS-1:0] first_x_in  [2];
   logic signed [COORD_BITS-1:0] first_y_in  [2];
   logic signed [COORD_BITS-1:0] recent_x_ff [2];
   logic signed [COORD_BITS-1:0] recent_y_ff [2];
   logic signed [COORD_BITS-1:0] recent_x_in [2];
   logic signed [COORD_BITS-1:0] recent_y_in [2];
   logic signed [COORD_BITS-1:0] pt_x_ff [POINT_SLOTS];
   logic signed [COORD_BITS-1:0] pt_y_ff [POINT_SLOTS];
   logic signed [COORD_BITS-1:0] pt_x_in [POINT_SLOTS];
   logic signed [COORD_BITS-1:0] pt_y_in [POINT_SLOTS];
   cpv_ctl_type                  ctl_ff, ctl_in;

   assign accept = req_valid && advance;
   assign active = count_ff < CNT_MAX;
   assign count_next = active ? (count_ff + CNT_W'(1)) : CNT_OVER;

   always_comb begin
      first_x_in  = first_x_ff;
      first_y_in  = first_y_ff;
      recent_x_in = recent_x_ff;
      recent_y_in = recent_y_ff;
      count_in    = count_ff;
      if (accept) begin
         if (active) begin
            if (count_ff == CNT_W'(0)) begin
               first_x_in[0] = req_vertex_x;
               first_y_in[0] = req_vertex_y;
            end
            if (count_ff == CNT_W'(1)) begin
               first_x_in[1] = req_vertex_x;
               first_y_in[1] = req_vertex_y;
            end
            recent_x_in[0] = recent_x_ff[1];
            recent_y_in[0] = recent_y_ff[1];
            recent_x_in[1] = req_vertex_x;
            recent_y_in[1] = req_vertex_y;
         end
         count_in = req_last_vertex ? '0 : count_next;
      end
   end

   always_comb begin
      pt_x_in[0] = recent_x_ff[0];
      pt_y_in[0] = recent_y_ff[0];
      pt_x_in[1] = recent_x_ff[1];
      pt_y_in[1] = recent_y_ff[1];
      pt_x_in[2] = req_vertex_x;
      pt_y_in[2] = req_vertex_y;
      pt_x_in[3] = first_x_in[0];
      pt_y_in[3] = first_y_in[0];
      pt_x_in[4] = first_x_in[1];
      pt_y_in[4] = first_y_in[1];

      ctl_in.valid        = accept;
      ctl_in.last         = req_last_vertex;
      ctl_in.too_many     = count_next > CNT_MAX;
      ctl_in.few          = count_next < CNT_W'(3);
      ctl_in.corner_en[0] = active && (count_ff >= CNT_W'(2));
      ctl_in.corner_en[1] = req_last_vertex && !ctl_in.too_many && !ctl_in.few;
      ctl_in.corner_en[2] = ctl_in.corner_en[1];
      ctl_in.edge_en[0]   = active && (count_ff >= CNT_W'(1));
      ctl_in.edge_en[1]   = req_last_vertex && !ctl_in.too_many;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ctl_ff   <= '0;
      end else begin
         count_ff <= count_in;
         if (advance) begin
            ctl_ff <= ctl_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      first_x_ff  <= first_x_in;
      first_y_ff  <= first_y_in;
      recent_x_ff <= recent_x_in;
      recent_y_ff <= recent_y_in;
      if (advance) begin
         pt_x_ff <= pt_x_in;
         pt_y_ff <= pt_y_in;
      end
   end

   assign pt_x = pt_x_ff;
   assign pt_y = pt_y_ff;
   assign ctl  = ctl_ff;

endmodule

`default_nettype wire

/* rtl/cpv_arith.sv */
// Multiply, subtract and classify stages for corner cross products and shoelace edge terms.
`default_nettype none

module cpv_arith #(
   parameter int COORD_BITS = cpv_pkg::COORD_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    advance,
   input  logic [cpv_pkg::TURN_TOL_BITS-1:0]       turn_tol,
   input  logic signed [cpv_pkg::TURN_TOL_BITS:0]  turn_tol_neg,
   input  logic signed [COORD_BITS-1:0]            pt_x [cpv_pkg::POINT_SLOTS],
   input  logic signed [COORD_BITS-1:0]            pt_y [cpv_pkg::POINT_SLOTS],
   input  cpv_pkg::cpv_ctl_type                    ctl_in_s1,
   output logic [cpv_pkg::TURN_BITS-1:0]           turn [cpv_pkg::CORNER_LANES],
   output logic signed [2*COORD_BITS+1:0]          edge_sum,
   output cpv_pkg::cpv_ctl_type                    ctl
);
   import cpv_pkg::*;

   localparam int DIFF_W = COORD_BITS + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int EPROD_W = 2 * COORD_BITS;
   localparam int EDGE_W = EPROD_W + 1;
   localparam int ESUM_W = EDGE_W + 1;
   localparam int CMP_W = (CROSS_W > TURN_TOL_BITS + 2) ? CROSS_W : TURN_TOL_BITS + 2;

   // Corner lane differences: a to b and b to c.
   logic signed [DIFF_W-1:0]  ab_dx [CORNER_LANES];
   logic signed [DIFF_W-1:0]  ab_dy [CORNER_LANES];
   logic signed [DIFF_W-1:0]  bc_dx [CORNER_LANES];
   logic signed [DIFF_W-1:0]  bc_dy [CORNER_LANES];

   logic signed [PROD_W-1:0]  prod_p_ff [CORNER_LANES];
   logic signed [PROD_W-1:0]  prod_q_ff [CORNER_LANES];
   logic signed [PROD_W-1:0]  prod_p_in [CORNER_LANES];
   logic signed [PROD_W-1:0]  prod_q_in [CORNER_LANES];
   logic signed [EPROD_W-1:0] eprod_p_ff [EDGE_LANES];
   logic signed [EPROD_W-1:0] eprod_q_ff [EDGE_LANES];
   logic signed [EPROD_W-1:0] eprod_p_in [EDGE_LANES];
   logic signed [EPROD_W-1:0] eprod_q_in [EDGE_LANES];

   logic signed [CROSS_W-1:0] cross_ff [CORNER_LANES];
   logic signed [CROSS_W-1:0] cross_in [CORNER_LANES];
   logic signed [EDGE_W-1:0]  edge_ff [EDGE_LANES];
   logic signed [EDGE_W-1:0]  edge_in [EDGE_LANES];

   logic [TURN_BITS-1:0]      turn_ff [CORNER_LANES];
   logic [TURN_BITS-1:0]      turn_in [CORNER_LANES];
   logic signed [ESUM_W-1:0]  esum_ff, esum_in;
   logic signed [ESUM_W-1:0]  esum_a, esum_b;
   logic signed [CMP_W-1:0]   cross_ext [CORNER_LANES];
   logic signed [CMP_W-1:0]   tol_pos_ext, tol_neg_ext;

   cpv_ctl_type ctl2_ff, ctl3_ff, ctl4_ff;

   // Stage two: differences and products, corner k spans points k, k+1, k+2.
   always_comb begin
      for (int k = 0; k < CORNER_LANES; k++) begin
         ab_dx[k] = DIFF_W'(pt_x[k + 1]) - DIFF_W'(pt_x[k]);
         ab_dy[k] = DIFF_W'(pt_y[k + 1]) - DIFF_W'(pt_y[k]);
         bc_dx[k] = DIFF_W'(pt_x[k + 2]) - DIFF_W'(pt_x[k + 1]);
         bc_dy[k] = DIFF_W'(pt_y[k + 2]) - DIFF_W'(pt_y[k + 1]);
         prod_p_in[k] = PROD_W'(ab_dx[k]) * PROD_W'(bc_dy[k]);
         prod_q_in[k] = PROD_W'(ab_dy[k]) * PROD_W'(bc_dx[k]);
      end
      // Edge j runs from point j+1 to point j+2.
      for (int j = 0; j < EDGE_LANES; j++) begin
         eprod_p_in[j] = EPROD_W'(pt_x[j + 1]) * EPROD_W'(pt_y[j + 2]);
         eprod_q_in[j] = EPROD_W'(pt_x[j + 2]) * EPROD_W'(pt_y[j + 1]);
      end
   end

   // Stage three: cross products and edge terms.
   always_comb begin
      for (int k = 0; k < CORNER_LANES; k++) begin
         cross_in[k] = CROSS_W'(prod_p_ff[k]) - CROSS_W'(prod_q_ff[k]);
      end
      for (int j = 0; j < EDGE_LANES; j++) begin
         edge_in[j] = EDGE_W'(eprod_p_ff[j]) - EDGE_W'(eprod_q_ff[j]);
      end
   end

   // Stage four: turn direction against the tolerance band, and the summed edge terms.
   assign tol_pos_ext = $signed(CMP_W'({1'b0, turn_tol}));
   assign tol_neg_ext = CMP_W'(turn_tol_neg);

   always_comb begin
      for (int k = 0; k < CORNER_LANES; k++) begin
         cross_ext[k] = CMP_W'(cross_ff[k]);
         if (cross_ext[k] > tol_pos_ext) begin
            turn_in[k] = TURN_LEFT;
         end else if (cross_ext[k] < tol_neg_ext) begin
            turn_in[k] = TURN_RIGHT;
         end else begin
            turn_in[k] = TURN_NONE;
         end
      end
      esum_a  = ctl3_ff.edge_en[0] ? ESUM_W'(edge_ff[0]) : '0;
      esum_b  = ctl3_ff.edge_en[1] ? ESUM_W'(edge_ff[1]) : '0;
      esum_in = esum_a + esum_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
      end else if (advance) begin
         ctl2_ff <= ctl_in_s1;
         ctl3_ff <= ctl2_ff;
         ctl4_ff <= ctl3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_p_ff  <= prod_p_in;
         prod_q_ff  <= prod_q_in;
         eprod_p_ff <= eprod_p_in;
         eprod_q_ff <= eprod_q_in;
         cross_ff   <= cross_in;
         edge_ff    <= edge_in;
         turn_ff    <= turn_in;
         esum_ff    <= esum_in;
      end
   end

   assign turn     = turn_ff;
   assign edge_sum = esum_ff;
   assign ctl      = ctl4_ff;

endmodule

`default_nettype wire

/* rtl/cpv_track.sv */
// Turn-sign agreement, area accumulation and the status result register.
`default_nettype none

module cpv_track #(
   parameter int COORD_BITS = cpv_pkg::COORD_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    advance,
   input  logic [cpv_pkg::AREA_TOL_BITS-1:0]       area_tol,
   input  logic signed [cpv_pkg::AREA_BITS-1:0]    area_tol_neg,
   input  logic [cpv_pkg::TURN_BITS-1:0]           turn [cpv_pkg::CORNER_LANES],
   input  logic signed [2*COORD_BITS+1:0]          edge_sum,
   input  cpv_pkg::cpv_ctl_type                    ctl,
   output logic                                    rsp_valid,
   output logic [cpv_pkg::STATUS_BITS-1:0]         rsp_status,
   output logic signed [cpv_pkg::AREA_BITS-1:0]    rsp_double_area
);
   import cpv_pkg::*;

   localparam int ESUM_W = 2 * COORD_BITS + 2;
   localparam int EXT_W  = (ESUM_W > AREA_BITS) ? ESUM_W : AREA_BITS;

   logic [TURN_BITS-1:0]        agreed_ff, agreed_in;
   logic [STATUS_BITS-1:0]      fault_ff, fault_in;
   logic signed [AREA_BITS-1:0] area_ff, area_in;
   logic signed [EXT_W-1:0]     esum_ext;

   logic                        fin_valid_ff;
   logic                        fin_too_many_ff;
   logic                        fin_few_ff;
   logic [TURN_BITS-1:0]        fin_agreed_ff;
   logic [STATUS_BITS-1:0]      fin_fault_ff;
   logic signed [AREA_BITS-1:0] fin_area_ff;

   logic                        area_small;
   logic [STATUS_BITS-1:0]      status_in;
   logic signed [AREA_BITS-1:0] out_area_in;

   logic                        rsp_valid_ff;
   logic [STATUS_BITS-1:0]      rsp_status_ff;
   logic signed [AREA_BITS-1:0] rsp_area_ff;

   // Corners fold in order; once a fault is latched later corners are ignored.
   always_comb begin
      agreed_in = agreed_ff;
      fault_in  = fault_ff;
      for (int k = 0; k < CORNER_LANES; k++) begin
         if (ctl.corner_en[k] && (fault_in == STATUS_OK)) begin
            if (turn[k] == TURN_NONE) begin
               fault_in = STATUS_COLLINEAR;
            end else if (agreed_in == TURN_NONE) begin
               agreed_in = turn[k];
            end else if (agreed_in != turn[k]) begin
               fault_in = STATUS_NOT_CONVEX;
            end
         end
      end
      esum_ext = EXT_W'(edge_sum);
      area_in  = area_ff + esum_ext[AREA_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         agreed_ff    <= TURN_NONE;
         fault_ff     <= STATUS_OK;
         area_ff      <= '0;
         fin_valid_ff <= 1'b0;
      end else if (advance) begin
         fin_valid_ff <= ctl.valid && ctl.last;
         if (ctl.valid) begin
            if (ctl.last) begin
               agreed_ff <= TURN_NONE;
               fault_ff  <= STATUS_OK;
               area_ff   <= '0;
            end else begin
               agreed_ff <= agreed_in;
               fault_ff  <= fault_in;
               area_ff   <= area_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fin_too_many_ff <= ctl.too_many;
         fin_few_ff      <= ctl.few;
         fin_agreed_ff   <= agreed_in;
         fin_fault_ff    <= fault_in;
         fin_area_ff     <= area_in;
      end
   end

   // |area| < tolerance, tested on the sign without forming the magnitude.
   assign area_small = fin_area_ff[AREA_BITS-1] ? (fin_area_ff > area_tol_neg)
                                                : (fin_area_ff[AREA_BITS-2:0] < area_tol);

   always_comb begin
      out_area_in = fin_area_ff;
      if (fin_too_many_ff) begin
         status_in   = STATUS_TOO_MANY;
         out_area_in = '0;
      end else if (fin_few_ff) begin
         status_in = STATUS_TOO_FEW;
      end else if (area_small) begin
         status_in = STATUS_ZERO_AREA;
      end else if (fin_fault_ff != STATUS_OK) begin
         status_in = fin_fault_ff;
      end else if (fin_agreed_ff != TURN_LEFT) begin
         status_in = STATUS_CLOCKWISE;
      end else begin
         status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= fin_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff <= status_in;
         rsp_area_ff   <= out_area_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_double_area = rsp_area_ff;

endmodule

`default_nettype wire

/* rtl/cpv_checker.sv */
// Port-level assertions for the convex polygon validator and their bind.
`default_nettype none

`include "convex_polygon_validator_unit_macros.svh"

module cpv_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_stall,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic [cpv_pkg::STATUS_BITS-1:0]       rsp_status,
   input  logic signed [cpv_pkg::AREA_BITS-1:0]  rsp_double_area
);
   import cpv_pkg::*;

   logic rsp_blocked;

   assign rsp_blocked = rsp_valid && rsp_stall;

   `CPV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_blocked,
                    rsp_valid && $stable(rsp_status) && $stable(rsp_double_area),
                    "response changed while stalled")

   `CPV_ASSERT_IMPLY(a_req_stall_cause, clock, reset, req_stall, rsp_blocked,
                     "requests stalled without a blocked response")

   `CPV_ASSERT_IMPLY(a_too_many_area, clock, reset,
                     rsp_valid && (rsp_status == STATUS_TOO_MANY), rsp_double_area == '0,
                     "too many vertices reported with a nonzero area")

   `CPV_ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, !rsp_valid,
                    "response valid right after reset")

endmodule

bind convex_polygon_validator_unit cpv_checker u_cpv_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_double_area (rsp_double_area)
);

`default_nettype wire
